@@ rtl/ihp_pkg.sv @@
package ihp_pkg;

    // Default queue depths; the result queue must hold the largest burst of one character.
    localparam int TOKQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 4;
    localparam int MAX_RES    = 3;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SEEK,
        PH_LINE,
        PH_BETWEEN,
        PH_AFTER_EOF,
        PH_STOP
    } t_phase;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_ACCEPT,
        KIND_DONE,
        KIND_ERROR
    } t_kind;

    // Status codes carried by line and text results.
    typedef enum logic [3:0] {
        ST_NONE,
        ST_NO_COLON,
        ST_BAD_HEADER,
        ST_BAD_LENGTH,
        ST_NON_HEX,
        ST_CHECKSUM,
        ST_OVERFLOW,
        ST_BAD_EOF,
        ST_UNSUPPORTED,
        ST_AFTER_EOF,
        ST_TRAILING,
        ST_INCOMPLETE
    } t_status;

    // One classified character as it travels from the front end to the parser.
    typedef struct packed {
        logic [3:0] nibble;
        logic       nonhex;
        logic       colon;
        logic       line_end;
        logic       blank;
        logic       last;
    } t_token;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  record_type;
        logic        run_last;
    } t_result;

    // Burst of results that the parser writes in the same cycle.
    typedef struct packed {
        logic [1:0]                num;
        t_result [MAX_RES-1:0]     res;
    } t_res_write;

    function automatic t_result mk_result(t_kind k, t_status s, logic [31:0] a,
                                          logic [7:0] d, logic [7:0] ty);
        t_result r;
        r.kind        = k;
        r.status      = s;
        r.address     = a;
        r.data_byte   = d;
        r.record_type = ty;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/ihp_front.sv @@
module ihp_front
    import ihp_pkg::*;
#(
    parameter int P_DEPTH = TOKQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_full,
    output logic       o_tok_valid,
    output t_token     o_tok,
    input  logic       i_tok_take
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] OFS_UP   = 8'h37;
    localparam logic [7:0] OFS_LOW  = 8'h57;

    t_token        r_q [P_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    t_token        tok_in;
    logic          accept;

    // Decode the character into a hex digit and the few classes the parser needs.
    always_comb begin
        logic [7:0] diff;
        diff = 8'd0;
        tok_in.nonhex = 1'b0;
        if (i_char >= CH_DIG0 && i_char <= CH_DIG9) begin
            diff = i_char - CH_DIG0;
        end else if (i_char >= CH_UP_A && i_char <= CH_UP_F) begin
            diff = i_char - OFS_UP;
        end else if (i_char >= CH_LOW_A && i_char <= CH_LOW_F) begin
            diff = i_char - OFS_LOW;
        end else begin
            tok_in.nonhex = 1'b1;
        end
        tok_in.nibble   = diff[3:0];
        tok_in.colon    = (i_char == CH_COLON);
        tok_in.line_end = (i_char == CH_CR) || (i_char == CH_LF);
        tok_in.blank    = (i_char == CH_SPACE) || (i_char == CH_TAB);
        tok_in.last     = i_last;
    end

    assign o_full      = (r_count == CW'(P_DEPTH));
    assign accept      = i_push && !o_full;
    assign o_tok_valid = (r_count != CW'(0));
    assign o_tok       = r_q[r_rd_ptr];

    // Token queue storage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= tok_in;
        end
    end

    // Token queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= (r_wr_ptr == PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_tok_take) begin
                r_rd_ptr <= (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(accept) - CW'(i_tok_take);
        end
    end

endmodule

@@ rtl/ihp_back.sv @@
module ihp_back
    import ihp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tok_valid,
    input  t_token     i_tok,
    output logic       o_tok_take,
    input  logic       i_room,
    output t_res_write o_wr
);

    localparam logic [9:0] MIN_LINE     = 10'd11;
    localparam logic [9:0] LEN_SAT      = 10'd1023;
    localparam logic [9:0] HDR_LAST_POS = 10'd8;
    localparam logic [7:0] REC_DATA     = 8'h00;
    localparam logic [7:0] REC_EOF      = 8'h01;
    localparam logic [7:0] REC_ESA      = 8'h02;
    localparam logic [7:0] REC_SSA      = 8'h03;
    localparam logic [7:0] REC_ELA      = 8'h04;
    localparam logic [7:0] REC_SLA      = 8'h05;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_len, n_len;
    logic [3:0]  r_hi, n_hi;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_offset, n_offset;
    logic [7:0]  r_rkind, n_rkind;
    logic [15:0] r_ext, n_ext;
    logic [31:0] r_base, n_base;
    logic [32:0] r_start, n_start;
    logic        r_data_seen, n_data_seen;
    logic        r_eof_seen, n_eof_seen;
    logic        r_hdr_bad, n_hdr_bad;
    logic        r_nonhex, n_nonhex;
    t_result [MAX_RES-1:0] res;
    logic [1:0]  res_num;

    // The parser steps one character whenever the result queue can take a full burst.
    assign o_tok_take = i_tok_valid && i_room;
    assign o_wr.num   = o_tok_take ? res_num : 2'd0;
    assign o_wr.res   = res;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEEK;
            r_len       <= '0;
            r_hi        <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_offset    <= '0;
            r_rkind     <= '0;
            r_ext       <= '0;
            r_base      <= '0;
            r_data_seen <= 1'b0;
            r_eof_seen  <= 1'b0;
            r_hdr_bad   <= 1'b0;
            r_nonhex    <= 1'b0;
        end else if (o_tok_take) begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_hi        <= n_hi;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_offset    <= n_offset;
            r_rkind     <= n_rkind;
            r_ext       <= n_ext;
            r_base      <= n_base;
            r_data_seen <= n_data_seen;
            r_eof_seen  <= n_eof_seen;
            r_hdr_bad   <= n_hdr_bad;
            r_nonhex    <= n_nonhex;
        end
    end

    // The line start address is data and needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_tok_take) begin
            r_start <= n_start;
        end
    end

    // Next state and result burst for the character at the head of the token queue.
    always_comb begin
        logic [9:0]  p;
        logic [3:0]  dv;
        logic [7:0]  b;
        logic [8:0]  k;
        logic [32:0] last_addr;
        logic [7:0]  ty;
        t_status     st;
        logic [1:0]  cnt;
        logic        do_start;

        n_phase     = r_phase;
        n_len       = r_len;
        n_hi        = r_hi;
        n_sum       = r_sum;
        n_count     = r_count;
        n_offset    = r_offset;
        n_rkind     = r_rkind;
        n_ext       = r_ext;
        n_base      = r_base;
        n_start     = r_start;
        n_data_seen = r_data_seen;
        n_eof_seen  = r_eof_seen;
        n_hdr_bad   = r_hdr_bad;
        n_nonhex    = r_nonhex;
        res         = '0;
        cnt         = 2'd0;
        do_start    = 1'b0;
        p           = r_len;
        dv          = 4'd0;
        b           = 8'd0;
        k           = 9'd0;
        last_addr   = '0;
        ty          = 8'd0;
        st          = ST_NONE;

        case (r_phase)
            PH_SEEK: begin
                do_start = i_tok.colon;
            end
            PH_LINE: begin
                if (!i_tok.line_end) begin
                    // Feed one character of the record line.
                    n_len = (r_len < LEN_SAT) ? r_len + 10'd1 : r_len;
                    dv    = i_tok.nibble;
                    if (i_tok.nonhex) begin
                        if (p <= HDR_LAST_POS) begin
                            n_hdr_bad = 1'b1;
                        end else begin
                            n_nonhex = 1'b1;
                        end
                        dv = 4'd0;
                    end
                    if (p[0]) begin
                        n_hi = dv;
                    end else begin
                        b     = {r_hi, dv};
                        k     = p[9:1] - 9'd1;
                        n_sum = r_sum + b;
                        if (k == 9'd0) begin
                            n_count = b;
                        end else if (k == 9'd1) begin
                            n_offset[15:8] = b;
                        end else if (k == 9'd2) begin
                            n_offset[7:0] = b;
                        end else if (k == 9'd3) begin
                            n_rkind = b;
                            n_start = {1'b0, r_base} + {17'd0, r_offset};
                        end else begin
                            if (k == 9'd4) begin
                                n_ext[15:8] = b;
                            end else if (k == 9'd5) begin
                                n_ext[7:0] = b;
                            end
                            if (({1'b0, k} < 10'd4 + {2'd0, r_count}) &&
                                (r_rkind == REC_DATA) && !n_hdr_bad && !n_nonhex) begin
                                res[cnt] = mk_result(KIND_DATA, ST_NONE,
                                                     r_start[31:0] + {23'd0, k - 9'd4},
                                                     b, 8'd0);
                                cnt = cnt + 2'd1;
                            end
                        end
                    end
                end
            end
            PH_BETWEEN: begin
                if (i_tok.colon) begin
                    do_start = 1'b1;
                end else if (!i_tok.line_end) begin
                    res[cnt] = mk_result(KIND_ERROR, ST_TRAILING, 32'd0, 8'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    n_phase  = PH_STOP;
                end
            end
            PH_AFTER_EOF: begin
                if (!i_tok.line_end && !i_tok.blank) begin
                    res[cnt] = mk_result(KIND_ERROR, ST_AFTER_EOF, 32'd0, 8'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    n_phase  = PH_STOP;
                end
            end
            default: begin
            end
        endcase

        // A colon opens a fresh record line.
        if (do_start) begin
            n_phase    = PH_LINE;
            n_len      = 10'd1;
            n_hi       = 4'd0;
            n_sum      = 8'd0;
            n_count    = 8'd0;
            n_offset   = 16'd0;
            n_rkind    = 8'd0;
            n_ext      = 16'd0;
            n_hdr_bad  = 1'b0;
            n_nonhex   = 1'b0;
        end

        // Close the line on a line end or on the final character, first error wins.
        if (n_phase == PH_LINE && (i_tok.line_end || i_tok.last)) begin
            ty        = n_hdr_bad ? 8'd0 : n_rkind;
            last_addr = r_start + {25'd0, n_count};
            if (n_len < MIN_LINE || n_hdr_bad) begin
                st = ST_BAD_HEADER;
            end else if (n_len != MIN_LINE + {1'b0, n_count, 1'b0}) begin
                st = ST_BAD_LENGTH;
            end else if (n_nonhex) begin
                st = ST_NON_HEX;
            end else if (n_sum != 8'd0) begin
                st = ST_CHECKSUM;
            end else if (n_rkind == REC_DATA) begin
                if (last_addr[32]) begin
                    st = ST_OVERFLOW;
                end else if (n_count != 8'd0) begin
                    n_data_seen = 1'b1;
                end
            end else if (n_rkind == REC_EOF) begin
                if (n_count != 8'd0 || n_offset != 16'd0) begin
                    st = ST_BAD_EOF;
                end else begin
                    n_eof_seen = 1'b1;
                end
            end else if ((n_rkind == REC_ESA || n_rkind == REC_ELA) &&
                         n_count == 8'd2 && n_offset == 16'd0) begin
                n_base = (n_rkind == REC_ESA) ? {12'd0, n_ext, 4'd0} : {n_ext, 16'd0};
            end else if ((n_rkind == REC_SSA || n_rkind == REC_SLA) &&
                         n_count == 8'd4 && n_offset == 16'd0) begin
                st = ST_NONE;
            end else begin
                st = ST_UNSUPPORTED;
            end
            if (st != ST_NONE) begin
                res[cnt] = mk_result(KIND_ERROR, st, 32'd0, 8'd0, ty);
                n_phase  = PH_STOP;
            end else begin
                res[cnt] = mk_result(KIND_ACCEPT, ST_NONE, r_start[31:0], 8'd0, ty);
                n_phase  = n_eof_seen ? PH_AFTER_EOF : PH_BETWEEN;
            end
            cnt = cnt + 2'd1;
        end

        // The final character reports the whole text and returns to the reset state.
        if (i_tok.last) begin
            if (n_phase == PH_SEEK) begin
                res[cnt] = mk_result(KIND_ERROR, ST_NO_COLON, 32'd0, 8'd0, 8'd0);
                cnt      = cnt + 2'd1;
            end else if (n_phase != PH_STOP) begin
                if (n_data_seen && n_eof_seen) begin
                    res[cnt] = mk_result(KIND_DONE, ST_NONE, 32'd0, 8'd0, 8'd0);
                end else begin
                    res[cnt] = mk_result(KIND_ERROR, ST_INCOMPLETE, 32'd0, 8'd0, 8'd0);
                end
                cnt = cnt + 2'd1;
            end
            n_phase     = PH_SEEK;
            n_len       = 10'd0;
            n_hi        = 4'd0;
            n_sum       = 8'd0;
            n_count     = 8'd0;
            n_offset    = 16'd0;
            n_rkind     = 8'd0;
            n_ext       = 16'd0;
            n_base      = 32'd0;
            n_data_seen = 1'b0;
            n_eof_seen  = 1'b0;
            n_hdr_bad   = 1'b0;
            n_nonhex    = 1'b0;
        end

        // Mark the last result of this character's burst.
        if (cnt != 2'd0) begin
            res[cnt - 2'd1].run_last = 1'b1;
        end
        res_num = cnt;
    end

endmodule

@@ rtl/ihp_resq.sv @@
module ihp_resq
    import ihp_pkg::*;
#(
    parameter int P_DEPTH = RESQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_res_write i_wr,
    output logic       o_room,
    output logic       o_empty,
    input  logic       i_pop,
    output t_result    o_head
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_result       r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wa [MAX_RES + 1];
    logic          pop_ok;

    // Consecutive write slots for a burst, wrapping at the queue depth.
    always_comb begin
        wa[0] = r_wr_ptr;
        for (int i = 1; i <= MAX_RES; i++) begin
            wa[i] = (wa[i-1] == PW'(P_DEPTH - 1)) ? '0 : wa[i-1] + PW'(1);
        end
    end

    assign o_room  = (r_count <= CW'(P_DEPTH - MAX_RES));
    assign o_empty = (r_count == CW'(0));
    assign pop_ok  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Result storage.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < i_wr.num) begin
                r_mem[wa[i]] <= i_wr.res[i];
            end
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= wa[i_wr.num];
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_wr.num) - CW'(pop_ok);
        end
    end

endmodule

@@ rtl/intel_hex_stream_parser.sv @@
// Channel   Handshake          Payload
// input     push / full        i_char_in, i_end_of_text
// result    empty / pop        o_kind, o_status, o_address, o_data_byte,
//                              o_record_type, o_run_last
//
// One character is taken per cycle while the token queue is not full; its results pass
// through the parser into the result queue, one result popped per cycle while not empty.
// The parser steps one character per cycle whenever the result queue has room for a
// three-result burst, so a character that yields two or three results holds later
// characters in the token queue until the consumer drains them.
// Reset is synchronous and active low; it empties both queues and returns the parser to
// its seeking state.
module intel_hex_stream_parser
    import ihp_pkg::*;
#(
    parameter int P_TOKQ_DEPTH = TOKQ_DEPTH,
    parameter int P_RESQ_DEPTH = RESQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_status,
    output logic [31:0] o_address,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_record_type,
    output logic        o_run_last
);

    logic       tok_valid;
    t_token     tok;
    logic       tok_take;
    logic       res_room;
    t_res_write wr;
    t_result    head;

    // Front end: character classification and token queue.
    ihp_front #(
        .P_DEPTH (P_TOKQ_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char      (i_char_in),
        .i_last      (i_end_of_text),
        .o_full      (full),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_take  (tok_take)
    );

    // Back end: record parser.
    ihp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_take  (tok_take),
        .i_room      (res_room),
        .o_wr        (wr)
    );

    // Result queue.
    ihp_resq #(
        .P_DEPTH (P_RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_room  (res_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (head)
    );

    assign o_kind        = head.kind;
    assign o_status      = head.status;
    assign o_address     = head.address;
    assign o_data_byte   = head.data_byte;
    assign o_record_type = head.record_type;
    assign o_run_last    = head.run_last;

`ifndef NO_ASSERTIONS
    // A result can only become visible after the parser wrote a burst.
    a_fill_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(wr.num != 2'd0))
        else $error("result queue filled without a parser write");

    // Data results carry no status and no record type.
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_DATA) |-> (o_status == ST_NONE && o_record_type == 8'd0))
        else $error("data result with status or record type");

    // Error results carry neither address nor data.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ERROR) |-> (o_address == 32'd0 && o_data_byte == 8'd0))
        else $error("error result with address or data");

    // A complete-text result always closes its character's burst.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_DONE) |-> o_run_last)
        else $error("text complete result not marked last");
`endif

endmodule

@@ tb/sv/intel_hex_stream_parser_tb.sv @@
module intel_hex_stream_parser_tb;
    import ihp_pkg::*;

    // Character codes that the parser treats specially, and a junk character that is not a colon.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_JUNK  = 8'h78;

    // Intel HEX record types.
    localparam logic [7:0] REC_DATA      = 8'h00;
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_SEGMENT   = 8'h02;
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_LINEAR    = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    localparam int unsigned LINE_MIN = 11;
    localparam int unsigned LINE_SAT = 1023;
    localparam int unsigned HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_char_in = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_kind;
    logic [3:0]  o_status;
    logic [31:0] o_address;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_record_type;
    logic        o_run_last;

    intel_hex_stream_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_address     (o_address),
        .o_data_byte   (o_data_byte),
        .o_record_type (o_record_type),
        .o_run_last    (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // Results the parser still owes us, oldest first.
    t_result parser_results_due[$];
    int      fail_count = 0;
    bit      idle_on = 1'b0;
    bit      hold_request = 1'b0;
    int unsigned hold_left = 0;

    // Parser state as this bench tracks it.
    t_phase      parse_phase;
    int unsigned line_len;
    logic [3:0]  high_nib;
    logic [7:0]  run_sum;
    logic [7:0]  rec_count;
    logic [15:0] rec_offset;
    logic [7:0]  rec_type;
    logic [15:0] ext_word;
    logic [31:0] base_addr;
    bit          data_seen;
    bit          eof_seen;
    bit          header_bad;
    bit          nonhex_seen;

    // Text under construction and its running checksum.
    logic [7:0] text_q[$];
    logic [7:0] line_sum;

    // Directed stimulus: expected result typed in where it is obvious.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        t_kind      kind;
        t_status    status;
        logic [7:0] rtype;
    } t_stim_row;

    t_stim_row directed_rows [21];

    task automatic report_failure(input string msg);
        if (fail_count < 10) begin
            $display("%s", msg);
        end
        fail_count++;
    endtask

    task automatic add_result(input t_kind k, input t_status s, input logic [31:0] a,
                              input logic [7:0] d, input logic [7:0] t);
        t_result r;
        r.kind        = k;
        r.status      = s;
        r.address     = a;
        r.data_byte   = d;
        r.record_type = t;
        r.run_last    = 1'b0;
        parser_results_due.push_back(r);
    endtask

    task automatic clear_parse_state();
        parse_phase = PH_SEEK;
        line_len    = 0;
        high_nib    = '0;
        run_sum     = '0;
        rec_count   = '0;
        rec_offset  = '0;
        rec_type    = '0;
        ext_word    = '0;
        base_addr   = '0;
        data_seen   = 1'b0;
        eof_seen    = 1'b0;
        header_bad  = 1'b0;
        nonhex_seen = 1'b0;
    endtask

    task automatic open_line();
        parse_phase = PH_LINE;
        line_len    = 1;
        high_nib    = '0;
        run_sum     = '0;
        rec_count   = '0;
        rec_offset  = '0;
        rec_type    = '0;
        ext_word    = '0;
        header_bad  = 1'b0;
        nonhex_seen = 1'b0;
    endtask

    // Hex digit value, or 16 for anything that is not a hex digit.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        return 5'd16;
    endfunction

    // One character inside a record line; data bytes go out as soon as decoded.
    task automatic feed_char(input logic [7:0] c);
        int unsigned pos;
        int unsigned idx;
        logic [4:0]  d;
        logic [7:0]  b;
        pos = line_len;
        d   = digit_of(c);
        if (line_len < LINE_SAT) line_len++;
        if (d > 5'd15) begin
            if (pos <= 8) header_bad = 1'b1;
            else nonhex_seen = 1'b1;
            d = '0;
        end
        if (pos % 2 == 1) begin
            high_nib = d[3:0];
        end else begin
            b       = {high_nib, d[3:0]};
            idx     = (pos - 2) / 2;
            run_sum = run_sum + b;
            case (idx)
                0: rec_count = b;
                1: rec_offset[15:8] = b;
                2: rec_offset[7:0] = b;
                3: rec_type = b;
                default: begin
                    if (idx == 4) ext_word[15:8] = b;
                    else if (idx == 5) ext_word[7:0] = b;
                    if (idx < 4 + rec_count && rec_type == REC_DATA &&
                        !header_bad && !nonhex_seen) begin
                        add_result(KIND_DATA, ST_NONE,
                                   base_addr + 32'(rec_offset) + 32'(idx - 4), b, 8'h00);
                    end
                end
            endcase
        end
    endtask

    // Line end: accept the record or name its first error.
    task automatic close_line();
        t_status     st;
        logic [31:0] start;
        logic [7:0]  ty;
        longint unsigned top;
        st    = ST_NONE;
        start = base_addr + 32'(rec_offset);
        ty    = header_bad ? 8'h00 : rec_type;
        top   = longint'(base_addr) + longint'(rec_offset) + longint'(rec_count);
        if (line_len < LINE_MIN || header_bad) begin
            st = ST_BAD_HEADER;
        end else if (line_len != LINE_MIN + 2 * int'(rec_count)) begin
            st = ST_BAD_LENGTH;
        end else if (nonhex_seen) begin
            st = ST_NON_HEX;
        end else if (run_sum != 8'h00) begin
            st = ST_CHECKSUM;
        end else if (rec_type == REC_DATA) begin
            if (top > 64'hFFFF_FFFF) st = ST_OVERFLOW;
            else if (rec_count != 0) data_seen = 1'b1;
        end else if (rec_type == REC_EOF) begin
            if (rec_count != 0 || rec_offset != 0) st = ST_BAD_EOF;
            else eof_seen = 1'b1;
        end else if ((rec_type == REC_SEGMENT || rec_type == REC_LINEAR) &&
                     rec_count == 2 && rec_offset == 0) begin
            base_addr = (rec_type == REC_SEGMENT) ? {12'h000, ext_word, 4'h0}
                                                  : {ext_word, 16'h0000};
        end else if ((rec_type == REC_START_SEG || rec_type == REC_START_LIN) &&
                     rec_count == 4 && rec_offset == 0) begin
            // Start address records are accepted and have no effect.
        end else begin
            st = ST_UNSUPPORTED;
        end
        if (st != ST_NONE) begin
            add_result(KIND_ERROR, st, 32'h0, 8'h00, ty);
            parse_phase = PH_STOP;
        end else begin
            add_result(KIND_ACCEPT, ST_NONE, start, 8'h00, ty);
            parse_phase = eof_seen ? PH_AFTER_EOF : PH_BETWEEN;
        end
    endtask

    // Works out every result that one accepted request causes.
    task automatic parse_char(input logic [7:0] c, input logic eot);
        int      n0;
        logic    line_end;
        t_result r;
        n0       = parser_results_due.size();
        line_end = (c == CH_CR || c == CH_LF);
        case (parse_phase)
            PH_SEEK: begin
                if (c == CH_COLON) open_line();
            end
            PH_LINE: begin
                if (line_end) close_line();
                else feed_char(c);
            end
            PH_BETWEEN: begin
                if (c == CH_COLON) begin
                    open_line();
                end else if (!line_end) begin
                    add_result(KIND_ERROR, ST_TRAILING, 32'h0, 8'h00, 8'h00);
                    parse_phase = PH_STOP;
                end
            end
            PH_AFTER_EOF: begin
                if (!line_end && c != CH_SPACE && c != CH_TAB) begin
                    add_result(KIND_ERROR, ST_AFTER_EOF, 32'h0, 8'h00, 8'h00);
                    parse_phase = PH_STOP;
                end
            end
            default: ;
        endcase
        // The final character closes any open line and reports the whole text unless an error already stopped it.
        if (eot) begin
            if (parse_phase == PH_LINE) close_line();
            if (parse_phase == PH_SEEK) begin
                add_result(KIND_ERROR, ST_NO_COLON, 32'h0, 8'h00, 8'h00);
            end else if (parse_phase != PH_STOP) begin
                if (data_seen && eof_seen) add_result(KIND_DONE, ST_NONE, 32'h0, 8'h00, 8'h00);
                else add_result(KIND_ERROR, ST_INCOMPLETE, 32'h0, 8'h00, 8'h00);
            end
            clear_parse_state();
        end
        if (parser_results_due.size() > n0) begin
            r = parser_results_due.pop_back();
            r.run_last = 1'b1;
            parser_results_due.push_back(r);
        end
    endtask

    // Offers one request, with random gaps while idle_on is set, and returns once it is taken.
    task automatic send_char(input logic [7:0] c, input logic eot);
        while (idle_on && $urandom_range(99) < 22) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_char_in     <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + 8'(n);
        return ($urandom_range(1) ? "a" : "A") + 8'(n) - 8'd10;
    endfunction

    task automatic put_hex_byte(input logic [7:0] b);
        text_q.push_back(hex_char(b[7:4]));
        text_q.push_back(hex_char(b[3:0]));
        line_sum = line_sum + b;
    endtask

    // One record line; the checksum is occasionally spoiled.
    task automatic put_record(input logic [7:0] cnt, input logic [15:0] off,
                              input logic [7:0] rtype, input logic [31:0] payload);
        logic [7:0] b;
        text_q.push_back(CH_COLON);
        line_sum = '0;
        put_hex_byte(cnt);
        put_hex_byte(off[15:8]);
        put_hex_byte(off[7:0]);
        put_hex_byte(rtype);
        for (int i = 0; i < int'(cnt); i++) begin
            b = (rtype != REC_DATA && i < 4) ? payload[31 - 8 * i -: 8] : 8'($urandom);
            put_hex_byte(b);
        end
        b = -line_sum;
        if ($urandom_range(19) == 0) b = b ^ 8'($urandom_range(255, 1));
        put_hex_byte(b);
        case ($urandom_range(2))
            0: text_q.push_back(CH_CR);
            1: text_q.push_back(CH_LF);
            default: begin
                text_q.push_back(CH_CR);
                text_q.push_back(CH_LF);
            end
        endcase
    endtask

    // Mostly well-formed files with random content, some noise and broken ones.
    task automatic build_text();
        int unsigned pick;
        int unsigned pos;
        logic [7:0]  b;
        logic [7:0]  cnt;
        logic [15:0] off;
        text_q.delete();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(12, 1)) begin
                b = ($urandom_range(3) == 0) ? CH_COLON : 8'($urandom);
                text_q.push_back(b);
            end
            return;
        end
        repeat ($urandom_range(3)) begin
            b = 8'($urandom);
            text_q.push_back((b == CH_COLON) ? CH_JUNK : b);
        end
        repeat ($urandom_range(5, 1)) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                case ($urandom_range(9))
                    0: cnt = 8'd0;
                    9: cnt = 8'($urandom_range(16, 9));
                    default: cnt = 8'($urandom_range(8, 1));
                endcase
                off = ($urandom_range(3) == 0) ? 16'hFFF0 + 16'($urandom_range(15))
                                               : 16'($urandom);
                put_record(cnt, off, REC_DATA, 32'h0);
            end else if (pick < 65) begin
                put_record(8'd2, 16'h0000, REC_LINEAR,
                           {($urandom_range(1) ? 16'hFFFF : 16'($urandom)), 16'h0000});
            end else if (pick < 75) begin
                put_record(8'd2, 16'h0000, REC_SEGMENT, $urandom);
            end else if (pick < 85) begin
                put_record(8'd4, 16'h0000,
                           $urandom_range(1) ? REC_START_SEG : REC_START_LIN, $urandom);
            end else begin
                put_record(8'($urandom_range(4)), $urandom_range(1) ? 16'h0 : 16'($urandom),
                           8'($urandom_range(7)), $urandom);
            end
        end
        if ($urandom_range(99) < 85) put_record(8'd0, 16'h0000, REC_EOF, 32'h0);
        if ($urandom_range(4) == 0) begin
            // End the text in the middle of the last line.
            while (text_q[$] == CH_CR || text_q[$] == CH_LF) void'(text_q.pop_back());
        end else begin
            repeat ($urandom_range(2)) begin
                case ($urandom_range(3))
                    0: text_q.push_back(CH_SPACE);
                    1: text_q.push_back(CH_TAB);
                    2: text_q.push_back(CH_CR);
                    default: text_q.push_back(CH_LF);
                endcase
            end
        end
        if ($urandom_range(99) < 25) begin
            pos = $urandom_range(text_q.size() - 1);
            case ($urandom_range(2))
                0: text_q[pos] = 8'($urandom);
                1: if (text_q.size() > 1) text_q.delete(pos);
                default: text_q.insert(pos, 8'($urandom));
            endcase
        end
    endtask

    // A line long enough to saturate the character count.
    task automatic build_long_line();
        text_q.delete();
        text_q.push_back(CH_COLON);
        repeat (LINE_SAT + 10) text_q.push_back(hex_char(4'($urandom)));
        text_q.push_back(CH_LF);
    endtask

    // Result side: check each accepted result against the oldest expectation.
    task automatic check_result();
        t_result want;
        if (parser_results_due.size() == 0) begin
            report_failure($sformatf("unexpected result: kind %0d status %0d addr %h",
                                     o_kind, o_status, o_address));
            return;
        end
        want = parser_results_due.pop_front();
        if (o_kind !== want.kind || o_status !== want.status ||
            o_address !== want.address || o_data_byte !== want.data_byte ||
            o_record_type !== want.record_type || o_run_last !== want.run_last) begin
            report_failure($sformatf({"mismatch: expected kind %0d status %0d addr %h ",
                                      "data %h type %h last %0d, got kind %0d status %0d ",
                                      "addr %h data %h type %h last %0d"},
                                     want.kind, want.status, want.address, want.data_byte,
                                     want.record_type, want.run_last, o_kind, o_status,
                                     o_address, o_data_byte, o_record_type, o_run_last));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_result();
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= !(idle_on && $urandom_range(99) < 22);
        end
    end

    // Stimulus: directed table first, then random files.
    initial begin
        int unsigned rand_items;
        int unsigned text_no;
        int          n0;
        t_result     want;
        clear_parse_state();
        directed_rows = '{
            '{8'h00,    1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{8'hFF,    1'b1, 1'b1, KIND_ERROR,  ST_NO_COLON,   8'h00},
            '{CH_COLON, 1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"G",      1'b1, 1'b1, KIND_ERROR,  ST_BAD_HEADER, 8'h00},
            '{CH_COLON, 1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{CH_LF,    1'b0, 1'b1, KIND_ERROR,  ST_BAD_HEADER, 8'h00},
            '{"z",      1'b1, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{CH_COLON, 1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"0",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"0",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"0",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"0",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"0",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"0",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"0",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"1",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"F",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{"f",      1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{CH_CR,    1'b0, 1'b1, KIND_ACCEPT, ST_NONE,       REC_EOF},
            '{CH_SPACE, 1'b0, 1'b0, KIND_DATA,   ST_NONE,       8'h00},
            '{CH_TAB,   1'b1, 1'b1, KIND_ERROR,  ST_INCOMPLETE, 8'h00}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].ch, directed_rows[i].eot);
            n0 = parser_results_due.size();
            parse_char(directed_rows[i].ch, directed_rows[i].eot);
            if (directed_rows[i].typed) begin
                while (parser_results_due.size() > n0) void'(parser_results_due.pop_back());
                want.kind        = directed_rows[i].kind;
                want.status      = directed_rows[i].status;
                want.address     = 32'h0;
                want.data_byte   = 8'h00;
                want.record_type = directed_rows[i].rtype;
                want.run_last    = 1'b1;
                parser_results_due.push_back(want);
            end
        end

        // Random files; the first ones run with no gaps on either side.
        idle_on    = 1'b0;
        rand_items = 0;
        text_no    = 0;
        while (rand_items < 460) begin
            if (rand_items >= 120) idle_on = 1'b1;
            if (text_no == 4) hold_request = 1'b1;
            if (text_no == 8) begin
                while (parser_results_due.size() != 0) @(posedge i_clk);
            end
            if (text_no == 6) build_long_line();
            else build_text();
            foreach (text_q[i]) begin
                send_char(text_q[i], i == text_q.size() - 1);
                parse_char(text_q[i], i == text_q.size() - 1);
            end
            if (text_no != 6) rand_items += text_q.size();
            text_no++;
        end
        push <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (parser_results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
